// ===== sv/rdf_pkg.sv =====
// ----------------------------------------------------------------------------
// rdf_pkg - register datagram framer shared types and constants
// Frame layout type, CRC-8 byte update and fixed codes used by the framer.
// ----------------------------------------------------------------------------
package rdf_pkg;

    // Number of bytes ahead of the CRC in a write datagram
    localparam int unsigned BODY_BYTES = 7;

    // Datagram constants
    localparam logic [7:0] SYNC_RESET = 8'h05;
    localparam logic [7:0] CRC_POLY   = 8'h07;
    localparam logic [7:0] CRC_INIT   = 8'h00;

    // Request kinds carried on tuser
    localparam logic ACTION_READ  = 1'b0;
    localparam logic ACTION_WRITE = 1'b1;

    // Beat index of the CRC byte
    localparam logic [2:0] CRC_IDX_WRITE = 3'd7;
    localparam logic [2:0] CRC_IDX_READ  = 3'd3;

    // Datagram body, byte 0 sent first
    typedef struct packed {
        logic                  is_write;
        logic [6:0][7:0]       bytes;
    } t_frame;

    // Fold one byte into the CRC, least significant bit first
    function automatic logic [7:0] crc8_byte(input logic [7:0] crc_in,
                                             input logic [7:0] data);
        logic [7:0] crc;
        crc = crc_in;
        for (int b = 0; b < 8; b++) begin
            if (crc[7] ^ data[b]) begin
                crc = {crc[6:0], 1'b0} ^ CRC_POLY;
            end else begin
                crc = {crc[6:0], 1'b0};
            end
        end
        return crc;
    endfunction

endpackage

// ===== sv/register_datagram_framer_crc8.sv =====
// A request beat is registered in the capture stage and then loaded into the
// serialiser, which drives the first master byte. One byte per cycle while
// m_axis_tready is high; a read datagram has 4 bytes, a write 8, one per beat.
// A new request is taken while the previous datagram is still going out.
// Reset (synchronous, active low) empties both stages and sets sync to 0x05.
// ----------------------------------------------------------------------------
// register_datagram_framer_crc8 - register request to serial datagram framer
// Builds read and write register datagrams with a closing CRC-8 (poly 0x07,
// init 0, LSB first) and streams them out one byte per beat.
// ----------------------------------------------------------------------------
module register_datagram_framer_crc8 (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_we,
    input  logic [7:0]  i_cfg_wdata,     // sync_byte
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [47:0] s_axis_tdata,    // node_address[7:0], register_address[14:8],
                                         // write_data[46:15], zero pad[47]
    input  logic        s_axis_tuser,    // action
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [7:0]  m_axis_tdata,    // frame_byte
    output logic        m_axis_tlast     // last_byte
);

    logic            r_sync;
    logic [7:0]      r_sync_byte;
    logic            w_req_valid;
    logic            w_req_ready;
    rdf_pkg::t_frame w_frame;

    // Sync byte register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sync_byte <= rdf_pkg::SYNC_RESET;
        end else if (i_cfg_we) begin
            r_sync_byte <= i_cfg_wdata;
        end
    end

    // Track whether the sync byte has been rewritten since reset
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sync <= 1'b0;
        end else if (i_cfg_we) begin
            r_sync <= 1'b1;
        end
    end

    rdf_req_reg u_req (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_sync     (r_sync_byte),
        .i_valid    (s_axis_tvalid),
        .o_ready    (s_axis_tready),
        .i_action   (s_axis_tuser),
        .i_node     (s_axis_tdata[7:0]),
        .i_raddr    (s_axis_tdata[14:8]),
        .i_data     (s_axis_tdata[46:15]),
        .o_valid    (w_req_valid),
        .i_ready    (w_req_ready),
        .o_frame    (w_frame)
    );

    rdf_serialiser u_ser (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (w_req_valid),
        .o_ready (w_req_ready),
        .i_frame (w_frame),
        .o_valid (m_axis_tvalid),
        .i_ready (m_axis_tready),
        .o_byte  (m_axis_tdata),
        .o_last  (m_axis_tlast)
    );

    // A datagram never stops short of its CRC beat
    a_frame_continues: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && m_axis_tready && !m_axis_tlast |=> m_axis_tvalid)
        else $error("datagram ended without a last beat");

    // Back-pressure on requests only when the capture stage is full
    a_ready_when_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !s_axis_tready |-> w_req_valid)
        else $error("request stage stalled while empty");

    // A waiting request follows the last beat without a gap
    a_no_gap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && m_axis_tready && m_axis_tlast && w_req_valid |=> m_axis_tvalid)
        else $error("gap between back-to-back datagrams");

    // Sync register follows the last write once written
    a_sync_write: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cfg_we |=> r_sync && (r_sync_byte == $past(i_cfg_wdata)))
        else $error("sync byte write lost");

endmodule

// ===== sv/rdf_req_reg.sv =====
// ----------------------------------------------------------------------------
// rdf_req_reg - request capture stage
// Registers one request beat and lays it out as the datagram body bytes.
// ----------------------------------------------------------------------------
module rdf_req_reg (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic [7:0]          i_sync,
    input  logic                i_valid,
    output logic                o_ready,
    input  logic                i_action,
    input  logic [7:0]          i_node,
    input  logic [6:0]          i_raddr,
    input  logic [31:0]         i_data,
    output logic                o_valid,
    input  logic                i_ready,
    output rdf_pkg::t_frame     o_frame
);

    logic            r_valid;
    rdf_pkg::t_frame r_frame;
    rdf_pkg::t_frame n_frame;

    // Accept when empty or when the held body moves on this cycle
    assign o_ready = !r_valid || i_ready;

    // Lay out the body: sync, node, address with kind bit, data high byte first
    always_comb begin
        n_frame.is_write = (i_action == rdf_pkg::ACTION_WRITE);
        n_frame.bytes[0] = i_sync;
        n_frame.bytes[1] = i_node;
        n_frame.bytes[2] = {i_action, i_raddr};
        n_frame.bytes[3] = i_data[31:24];
        n_frame.bytes[4] = i_data[23:16];
        n_frame.bytes[5] = i_data[15:8];
        n_frame.bytes[6] = i_data[7:0];
    end

    // Hold valid until the serialiser takes the body
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_ready) begin
            r_valid <= i_valid;
        end
    end

    // Capture payload on an accepted beat
    always_ff @(posedge i_clk) begin
        if (i_valid && o_ready) begin
            r_frame <= n_frame;
        end
    end

    assign o_valid = r_valid;
    assign o_frame = r_frame;

endmodule

// ===== sv/rdf_serialiser.sv =====
// ----------------------------------------------------------------------------
// rdf_serialiser - byte serialiser with running CRC
// Shifts the body out one beat per cycle while the receiver is ready (a read
// sends bytes 0-2 only), folds each byte into the CRC and ends with the CRC.
// ----------------------------------------------------------------------------
module rdf_serialiser (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_valid,
    output logic                o_ready,
    input  rdf_pkg::t_frame     i_frame,
    output logic                o_valid,
    input  logic                i_ready,
    output logic [7:0]          o_byte,
    output logic                o_last
);

    logic            r_busy;
    logic            r_is_write;
    logic [6:0][7:0] r_bytes;
    logic [2:0]      r_cnt;
    logic [7:0]      r_crc;
    logic [2:0]      w_crc_idx;
    logic            w_take;
    logic            w_load;

    // Current beat: body byte or the closing CRC
    assign w_crc_idx = r_is_write ? rdf_pkg::CRC_IDX_WRITE : rdf_pkg::CRC_IDX_READ;
    assign o_last    = (r_cnt == w_crc_idx);
    assign o_byte    = o_last ? r_crc : r_bytes[0];
    assign o_valid   = r_busy;

    assign w_take  = r_busy && i_ready;
    assign o_ready = !r_busy || (w_take && o_last);
    assign w_load  = i_valid && o_ready;

    // Frame in progress flag
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
        end else if (o_ready) begin
            r_busy <= i_valid;
        end
    end

    // Load a new body, or advance one byte and fold it into the CRC
    always_ff @(posedge i_clk) begin
        if (w_load) begin
            r_is_write <= i_frame.is_write;
            r_bytes    <= i_frame.bytes;
            r_cnt      <= 3'd0;
            r_crc      <= rdf_pkg::CRC_INIT;
        end else if (w_take && !o_last) begin
            r_bytes <= {8'h00, r_bytes[6:1]};
            r_cnt   <= r_cnt + 3'd1;
            r_crc   <= rdf_pkg::crc8_byte(r_crc, r_bytes[0]);
        end
    end

endmodule

// ===== sim/tb_register_datagram_framer_crc8.sv =====
// ----------------------------------------------------------------------------
// tb_register_datagram_framer_crc8 - self-checking bench for the datagram framer
// Feeds read and write register requests into the slave stream and checks every
// datagram byte and its last flag on the master stream against a local model of
// the framing and the CRC-8. Runs several sync settings and pacing phases,
// including a long receiver hold-off that backs the framer up.
// ----------------------------------------------------------------------------
module tb_register_datagram_framer_crc8;

    localparam int unsigned HOLD_CYCLES    = 300;
    localparam int unsigned WATCHDOG_LIMIT = 2000;
    localparam int unsigned DRAIN_CYCLES   = 8;

    typedef enum int {
        MODE_FREE,
        MODE_TX_IDLE,
        MODE_RX_STALL,
        MODE_BOTH,
        MODE_PRESSURE
    } t_pace;

    typedef struct packed {
        logic        action;
        logic [7:0]  node;
        logic [6:0]  raddr;
        logic [31:0] data;
    } t_reg_request;

    typedef struct packed {
        logic [7:0] frame_byte;
        logic       is_last;
    } t_frame_beat;

    logic        i_clk         = 1'b0;
    logic        i_rst_n       = 1'b0;
    logic        i_cfg_we      = 1'b0;
    logic [7:0]  i_cfg_wdata   = 8'h00;
    logic        s_axis_tvalid = 1'b0;
    logic        s_axis_tready;
    logic [47:0] s_axis_tdata  = '0;   // node_address[7:0], register_address[14:8],
                                       // write_data[46:15], zero pad[47]
    logic        s_axis_tuser  = 1'b0; // action
    logic        m_axis_tvalid;
    logic        m_axis_tready = 1'b0;
    logic [7:0]  m_axis_tdata;         // frame_byte
    logic        m_axis_tlast;         // last_byte

    t_reg_request request_q[$];
    t_frame_beat  datagram_bytes_q[$];
    t_reg_request cur_req;
    logic [7:0]   sync_model   = rdf_pkg::SYNC_RESET;
    t_pace        phase_mode   = MODE_FREE;
    logic         rx_hold      = 1'b0;
    logic         rx_hold_done = 1'b0;
    int unsigned  rx_hold_cnt  = 0;
    int unsigned  idle_cnt     = 0;
    int unsigned  n_errors     = 0;
    int unsigned  n_reads      = 0;
    int unsigned  n_writes     = 0;
    int unsigned  n_bytes      = 0;

    register_datagram_framer_crc8 DUT (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_wdata   (i_cfg_wdata),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tlast  (m_axis_tlast)
    );

    initial begin
        forever #1 i_clk = ~i_clk;
    end

    // Shift one byte into the CRC register, bit 0 first
    function automatic logic [7:0] crc_fold_byte(input logic [7:0] crc_in,
                                                 input logic [7:0] octet);
        logic [7:0] acc;
        logic       fb;
        acc = crc_in;
        for (int i = 0; i < 8; i++) begin
            fb  = acc[7] ^ octet[i];
            acc = {acc[6:0], 1'b0} ^ (fb ? rdf_pkg::CRC_POLY : 8'h00);
        end
        return acc;
    endfunction

    // Build the expected datagram for one accepted request
    task automatic predict_datagram(input t_reg_request r);
        logic [7:0] frame [8];
        logic [7:0] crc;
        int         len;
        frame[0] = sync_model;
        frame[1] = r.node;
        if (r.action == rdf_pkg::ACTION_WRITE) begin
            frame[2] = {1'b1, r.raddr};
            frame[3] = r.data[31:24];
            frame[4] = r.data[23:16];
            frame[5] = r.data[15:8];
            frame[6] = r.data[7:0];
            len      = 8;
            n_writes++;
        end else begin
            frame[2] = {1'b0, r.raddr};
            len      = 4;
            n_reads++;
        end
        crc = rdf_pkg::CRC_INIT;
        for (int k = 0; k < len - 1; k++) begin
            crc = crc_fold_byte(crc, frame[k]);
        end
        frame[len - 1] = crc;
        for (int k = 0; k < len; k++) begin
            datagram_bytes_q.push_back('{frame_byte: frame[k], is_last: (k == len - 1)});
        end
    endtask

    function automatic bit tx_idle_draw();
        case (phase_mode)
            MODE_TX_IDLE: return $urandom_range(99) < 73;
            MODE_BOTH:    return $urandom_range(99) < 17;
            default:      return 1'b0;
        endcase
    endfunction

    function automatic bit rx_ready_draw();
        if (rx_hold) begin
            return 1'b0;
        end
        case (phase_mode)
            MODE_RX_STALL: return $urandom_range(99) >= 73;
            MODE_BOTH:     return $urandom_range(99) >= 17;
            default:       return 1'b1;
        endcase
    endfunction

    // Drive request beats from the pending queue; predict on each accepted beat
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            s_axis_tvalid <= 1'b0;
        end else begin
            if (s_axis_tvalid && s_axis_tready) begin
                predict_datagram(cur_req);
            end
            if (!s_axis_tvalid || s_axis_tready) begin
                if (request_q.size() != 0 && !tx_idle_draw()) begin
                    cur_req = request_q.pop_front();
                    s_axis_tvalid <= 1'b1;
                    s_axis_tdata  <= {1'b0, cur_req.data, cur_req.raddr, cur_req.node};
                    s_axis_tuser  <= cur_req.action;
                end else begin
                    s_axis_tvalid <= 1'b0;
                end
            end
        end
    end

    // Check each output beat against the oldest expected byte
    always @(posedge i_clk) begin : monitor
        t_frame_beat want;
        if (!i_rst_n) begin
            m_axis_tready <= 1'b0;
        end else begin
            if (m_axis_tvalid && m_axis_tready) begin
                n_bytes++;
                if (datagram_bytes_q.size() == 0) begin
                    $display("%0t: unexpected beat, actual byte %02h last %b",
                             $time, m_axis_tdata, m_axis_tlast);
                    n_errors++;
                end else begin
                    want = datagram_bytes_q.pop_front();
                    if (m_axis_tdata !== want.frame_byte) begin
                        $display("%0t: frame_byte mismatch, expected %02h actual %02h",
                                 $time, want.frame_byte, m_axis_tdata);
                        n_errors++;
                    end
                    if (m_axis_tlast !== want.is_last) begin
                        $display("%0t: last_byte mismatch, expected %b actual %b",
                                 $time, want.is_last, m_axis_tlast);
                        n_errors++;
                    end
                end
            end
            m_axis_tready <= rx_ready_draw();
        end
    end

    // Hold the receiver off once for a long stretch in the pressure phase
    always @(posedge i_clk) begin
        if (phase_mode == MODE_PRESSURE && !rx_hold_done) begin
            if (rx_hold_cnt == HOLD_CYCLES) begin
                rx_hold      <= 1'b0;
                rx_hold_done <= 1'b1;
            end else begin
                rx_hold     <= 1'b1;
                rx_hold_cnt <= rx_hold_cnt + 1;
            end
        end
    end

    // End the run if no beat moves on either side for too long
    always @(posedge i_clk) begin
        if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) begin
            idle_cnt <= 0;
        end else begin
            idle_cnt <= idle_cnt + 1;
        end
        if (idle_cnt >= WATCHDOG_LIMIT) begin
            $display("%0t: no beat for %0d cycles", $time, idle_cnt);
            $display("[register_datagram_framer_crc8] ERROR");
            $finish;
        end
    end

    task automatic push_req(input logic act, input logic [7:0] node,
                            input logic [6:0] ra, input logic [31:0] data);
        request_q.push_back('{action: act, node: node, raddr: ra, data: data});
    endtask

    // Wait until every request is sent and every byte has come out
    task automatic wait_drained();
        while (request_q.size() != 0 || s_axis_tvalid || datagram_bytes_q.size() != 0) begin
            @(posedge i_clk);
        end
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    // Set the sync byte and pacing, then run a batch of random requests
    task automatic run_phase(input t_pace mode, input logic [7:0] sync, input int n);
        logic [7:0]  node;
        logic [6:0]  ra;
        logic [31:0] data;
        @(posedge i_clk);
        i_cfg_we    <= 1'b1;
        i_cfg_wdata <= sync;
        @(posedge i_clk);
        i_cfg_we    <= 1'b0;
        sync_model   = sync;
        phase_mode  <= mode;
        @(negedge i_clk);
        for (int i = 0; i < n; i++) begin
            case ($urandom_range(7))
                0:       node = 8'h00;
                1:       node = 8'hFF;
                default: node = 8'($urandom_range(255));
            endcase
            case ($urandom_range(7))
                0:       ra = 7'h00;
                1:       ra = 7'h7F;
                default: ra = 7'($urandom_range(127));
            endcase
            case ($urandom_range(7))
                0:       data = 32'h0000_0000;
                1:       data = 32'hFFFF_FFFF;
                default: data = $urandom;
            endcase
            push_req(1'($urandom_range(1)), node, ra, data);
        end
        wait_drained();
    endtask

    initial begin
        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Directed: reset sync value, field extremes, both request kinds
        @(negedge i_clk);
        push_req(rdf_pkg::ACTION_READ,  8'h00, 7'h00, 32'h0000_0000);
        push_req(rdf_pkg::ACTION_WRITE, 8'h00, 7'h00, 32'h0000_0000);
        push_req(rdf_pkg::ACTION_READ,  8'hFF, 7'h7F, 32'h0000_0000);
        push_req(rdf_pkg::ACTION_WRITE, 8'hFF, 7'h7F, 32'hFFFF_FFFF);
        push_req(rdf_pkg::ACTION_WRITE, 8'h01, 7'h01, 32'h8000_0001);
        push_req(rdf_pkg::ACTION_WRITE, 8'hAA, 7'h55, 32'hAAAA_AAAA);
        push_req(rdf_pkg::ACTION_WRITE, 8'h55, 7'h2A, 32'h5555_5555);
        // Read with data present: the data must not reach the datagram
        push_req(rdf_pkg::ACTION_READ,  8'h12, 7'h34, 32'hFFFF_FFFF);
        push_req(rdf_pkg::ACTION_READ,  8'hA5, 7'h5A, 32'hDEAD_BEEF);
        push_req(rdf_pkg::ACTION_WRITE, 8'h80, 7'h40, 32'h0102_0304);
        push_req(rdf_pkg::ACTION_WRITE, 8'h7F, 7'h3F, 32'hFF00_FF00);
        push_req(rdf_pkg::ACTION_READ,  8'h80, 7'h40, 32'h0000_0000);
        push_req(rdf_pkg::ACTION_READ,  8'h7F, 7'h3F, 32'h1234_5678);
        push_req(rdf_pkg::ACTION_WRITE, 8'h00, 7'h7F, 32'h00FF_00FF);
        push_req(rdf_pkg::ACTION_WRITE, 8'hFF, 7'h00, 32'h7FFF_FFFE);
        push_req(rdf_pkg::ACTION_READ,  8'h01, 7'h01, 32'h0000_0000);
        wait_drained();

        run_phase(MODE_TX_IDLE,  8'h00, 35);
        run_phase(MODE_RX_STALL, 8'hFF, 35);
        run_phase(MODE_BOTH,     8'($urandom_range(255)), 35);
        run_phase(MODE_PRESSURE, 8'hA5, 30);
        run_phase(MODE_FREE,     rdf_pkg::SYNC_RESET, 25);

        $display("covered %0d read and %0d write requests, %0d datagram bytes",
                 n_reads, n_writes, n_bytes);
        $display("sync settings 0x05/0x00/0xFF/random/0xA5, idle, stall and hold-off pacing");
        if (n_errors == 0) begin
            $display("[register_datagram_framer_crc8] OK");
        end else begin
            $display("[register_datagram_framer_crc8] ERROR");
        end
        $finish;
    end

endmodule

// ===== files.f =====
sv/rdf_pkg.sv
sv/rdf_req_reg.sv
sv/rdf_serialiser.sv
sv/register_datagram_framer_crc8.sv
sim/tb_register_datagram_framer_crc8.sv
